// ===== sv/slmb_pkg.sv =====
package slmb_pkg;

   // coordinate and result widths
   localparam int COORD_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;
   localparam int NUM_AXES           = 3;
   localparam int AXIS_BITS          = 2;

   // configuration register widths and reset values
   localparam int DR_BITS       = 24;
   localparam int SIDE_BITS     = 24;
   localparam int MF_BITS       = 10;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [DR_BITS-1:0]   DR_RESET   = DR_BITS'(307200);
   localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(204800);
   localparam logic [MF_BITS-1:0]   MF_RESET   = MF_BITS'(384);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DETECT_RANGE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CUBE_SIDE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MOVE_FACTOR  = 2'd2;

   // axis codes
   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

   // derived values: threshold below 2^26, move distance within +-2^27
   localparam int THR_BITS   = 26;
   localparam int DIST_BITS  = 28;
   localparam int DERIVE_LAT = 4;

   typedef struct packed {
      logic [THR_BITS-1:0]         thr;
      logic signed [DIST_BITS-1:0] move_dist;
      logic [SIDE_BITS-1:0]        half;
      logic [SIDE_BITS-1:0]        rest;
   } derive_type;

   // what one axis lane reports for the current request
   typedef struct packed {
      logic                near;
      logic                down;
      logic [OUT_BITS-1:0] old_low;
      logic [OUT_BITS-1:0] old_high;
      logic [OUT_BITS-1:0] edge_val;
   } lane_res_type;

endpackage

// ===== sv/slmb_ifs.sv =====
interface slmb_req_if;
   import slmb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] pos_x;
   logic signed [OUT_BITS-1:0] pos_y;
   logic signed [OUT_BITS-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface slmb_rsp_if;
   import slmb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] drop_min_x;
   logic signed [OUT_BITS-1:0] drop_min_y;
   logic signed [OUT_BITS-1:0] drop_min_z;
   logic signed [OUT_BITS-1:0] drop_max_x;
   logic signed [OUT_BITS-1:0] drop_max_y;
   logic signed [OUT_BITS-1:0] drop_max_z;
   logic [AXIS_BITS-1:0]       shift_axis;
   logic                       shift_down;
   logic                       last_slab;

   modport source (output valid, output drop_min_x, output drop_min_y, output drop_min_z,
                   output drop_max_x, output drop_max_y, output drop_max_z,
                   output shift_axis, output shift_down, output last_slab, input ready);
   modport sink   (input valid, input drop_min_x, input drop_min_y, input drop_min_z,
                   input drop_max_x, input drop_max_y, input drop_max_z,
                   input shift_axis, input shift_down, input last_slab, output ready);
endinterface

// ===== sv/slmb_derive.sv =====
module slmb_derive (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [slmb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [slmb_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output slmb_pkg::derive_type                   drv,
   output logic                                   busy
);
   import slmb_pkg::*;

   localparam int PT_BITS  = MF_BITS + DR_BITS;       // threshold product
   localparam int PB_BITS  = DR_BITS + MF_BITS + 2;   // signed excess product
   localparam int Q_SHIFT  = 8;                       // Q2.8 factor
   localparam int DF_BITS  = THR_BITS + 3;            // side - 2T
   localparam int N9_BITS  = DF_BITS + 4;             // times 9
   localparam int M_BITS   = N9_BITS - 2;             // after divide by 4
   localparam int U_BITS   = M_BITS - 1;
   localparam int MG_BITS  = 32;
   localparam int MG_SHIFT = 34;
   localparam int PQ_BITS  = U_BITS + MG_BITS;
   localparam logic [MG_BITS-1:0] DIV5_MAGIC = 32'hCCCC_CCCD;
   localparam int CNT_BITS = $clog2(DERIVE_LAT + 1);

   logic [DR_BITS-1:0]   dr_ff,   dr_in;
   logic [SIDE_BITS-1:0] side_ff, side_in;
   logic [MF_BITS-1:0]   mf_ff,   mf_in;
   logic [CNT_BITS-1:0]  cnt_ff,  cnt_in;

   logic [PT_BITS-1:0]          prod_t_ff, prod_t_in;
   logic signed [PB_BITS-1:0]   prod_b_ff, prod_b_in;
   logic signed [MF_BITS:0]     mf_off;

   logic [THR_BITS-1:0]         thr_ff, thr_in;
   logic signed [DF_BITS-1:0]   diff;
   logic signed [N9_BITS-1:0]   n9;
   logic signed [M_BITS-1:0]    m_val;
   logic [U_BITS-1:0]           u_ff, u_in;
   logic                        neg2_ff, neg2_in;
   logic signed [DIST_BITS-1:0] b2_ff, b2_in;

   logic [PQ_BITS-1:0]          prod_q;
   logic [DIST_BITS-1:0]        q_ff, q_in;
   logic                        neg3_ff;
   logic signed [DIST_BITS-1:0] b3_ff;

   logic signed [DIST_BITS-1:0] a_val;
   logic signed [DIST_BITS-1:0] dist_ff, dist_in;

   // register writes; any write reopens the settle window
   always_comb begin
      dr_in   = dr_ff;
      side_in = side_ff;
      mf_in   = mf_ff;
      cnt_in  = (cnt_ff != '0) ? cnt_ff - CNT_BITS'(1) : cnt_ff;
      if (csr_wr_en) begin
         cnt_in = CNT_BITS'(DERIVE_LAT);
         unique case (csr_index)
            CSR_DETECT_RANGE: dr_in   = csr_wdata[DR_BITS-1:0];
            CSR_CUBE_SIDE:    side_in = csr_wdata[SIDE_BITS-1:0];
            CSR_MOVE_FACTOR:  mf_in   = csr_wdata[MF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dr_ff   <= DR_RESET;
         side_ff <= SIDE_RESET;
         mf_ff   <= MF_RESET;
         cnt_ff  <= CNT_BITS'(DERIVE_LAT);
      end else begin
         dr_ff   <= dr_in;
         side_ff <= side_in;
         mf_ff   <= mf_in;
         cnt_ff  <= cnt_in;
      end
   end

   // stage 1: threshold product and excess product
   assign mf_off    = signed'((MF_BITS + 1)'(mf_ff)) - (MF_BITS + 1)'(256);
   assign prod_t_in = PT_BITS'(mf_ff) * PT_BITS'(dr_ff);
   assign prod_b_in = PB_BITS'(signed'({1'b0, dr_ff})) * PB_BITS'(mf_off);

   // stage 2: threshold, 9*(side - 2T)/4 split into sign and magnitude, excess scaled down
   always_comb begin
      thr_in  = prod_t_ff[PT_BITS-1:Q_SHIFT];
      diff    = signed'(DF_BITS'(side_ff)) - signed'(DF_BITS'({thr_in, 1'b0}));
      n9      = (N9_BITS'(diff) <<< 3) + N9_BITS'(diff);
      m_val   = M_BITS'(n9 >>> 2);
      neg2_in = m_val[M_BITS-1];
      u_in    = neg2_in ? U_BITS'(~m_val) : U_BITS'(m_val);
      b2_in   = DIST_BITS'(prod_b_ff >>> Q_SHIFT);
   end

   // stage 3: divide by five through the reciprocal
   assign prod_q = PQ_BITS'(u_ff) * PQ_BITS'(DIV5_MAGIC);
   assign q_in   = prod_q[MG_SHIFT +: DIST_BITS];

   // stage 4: restore sign (floor), take the larger distance
   always_comb begin
      a_val   = neg3_ff ? ~signed'(q_ff) : signed'(q_ff);
      dist_in = (a_val > b3_ff) ? a_val : b3_ff;
   end

   always_ff @(posedge clock) begin
      prod_t_ff <= prod_t_in;
      prod_b_ff <= prod_b_in;
      thr_ff    <= thr_in;
      u_ff      <= u_in;
      neg2_ff   <= neg2_in;
      b2_ff     <= b2_in;
      q_ff      <= q_in;
      neg3_ff   <= neg2_ff;
      b3_ff     <= b2_ff;
      dist_ff   <= dist_in;
   end

   assign drv.thr       = thr_ff;
   assign drv.move_dist = dist_ff;
   assign drv.half      = side_ff >> 1;
   assign drv.rest      = side_ff - (side_ff >> 1);
   assign busy          = (cnt_ff != '0);

endmodule

// ===== sv/slmb_lane.sv =====
module slmb_lane #(
   parameter int COORD_BITS = slmb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic signed [slmb_pkg::OUT_BITS-1:0] pos_in,
   input  logic                                 place,
   input  logic                                 apply,
   input  slmb_pkg::derive_type                 drv,
   output slmb_pkg::lane_res_type               res
);
   import slmb_pkg::*;

   localparam int W_BASE = (COORD_BITS > DIST_BITS) ? COORD_BITS + 2 : DIST_BITS + 2;
   localparam int W      = (W_BASE > OUT_BITS) ? W_BASE : OUT_BITS + 1;
   localparam logic signed [W-1:0] CMAX_W = W'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
   localparam logic signed [W-1:0] CMIN_W = ~CMAX_W;

   logic signed [COORD_BITS-1:0] low_ff, low_in;
   logic signed [COORD_BITS-1:0] high_ff, high_in;

   logic signed [W-1:0] pos_w, low_w, high_w, thr_w, dist_w, d_lo, d_hi;
   logic signed [COORD_BITS-1:0] pos_c, lo_dn, hi_dn, lo_up, hi_up, lo_pl, hi_pl;
   logic near_lo, near_hi;

   function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [W-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v > CMAX_W) begin
         r = CMAX_W[COORD_BITS-1:0];
      end else if (v < CMIN_W) begin
         r = CMIN_W[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // edge tests against the current box
   always_comb begin
      pos_c   = sat_c(W'(pos_in));
      pos_w   = W'(pos_c);
      low_w   = W'(low_ff);
      high_w  = W'(high_ff);
      thr_w   = signed'(W'(drv.thr));
      dist_w  = W'(signed'(drv.move_dist));
      d_lo    = pos_w - low_w;
      d_hi    = pos_w - high_w;
      near_lo = (d_lo <= thr_w) && (d_lo >= -thr_w);
      near_hi = (d_hi <= thr_w) && (d_hi >= -thr_w);
      lo_dn   = sat_c(low_w - dist_w);
      hi_dn   = sat_c(high_w - dist_w);
      lo_up   = sat_c(low_w + dist_w);
      hi_up   = sat_c(high_w + dist_w);
      lo_pl   = sat_c(pos_w - W'(drv.half));
      hi_pl   = sat_c(pos_w + W'(drv.rest));
   end

   // place or shift the box on this axis
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (place) begin
         low_in  = lo_pl;
         high_in = hi_pl;
      end else if (apply && near_lo) begin
         low_in  = lo_dn;
         high_in = hi_dn;
      end else if (apply && near_hi) begin
         low_in  = lo_up;
         high_in = hi_up;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   // report against the old box
   always_comb begin
      res.near     = near_lo || near_hi;
      res.down     = near_lo;
      res.old_low  = OUT_BITS'(low_w);
      res.old_high = OUT_BITS'(high_w);
      res.edge_val = near_lo ? OUT_BITS'(W'(hi_dn)) : OUT_BITS'(W'(lo_up));
   end

endmodule

// ===== sv/slmb_merge.sv =====
module slmb_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  slmb_pkg::lane_res_type lane_res [slmb_pkg::NUM_AXES],
   output logic                   can_take,
   slmb_rsp_if.source             rsp
);
   import slmb_pkg::*;

   logic                      pend_valid_ff, pend_valid_in;
   logic [NUM_AXES-1:0]       mask_ff, mask_in;
   logic [NUM_AXES-1:0]       down_ff;
   logic [OUT_BITS-1:0]       low_ff  [NUM_AXES];
   logic [OUT_BITS-1:0]       high_ff [NUM_AXES];
   logic [OUT_BITS-1:0]       edge_ff [NUM_AXES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]       min_ff [NUM_AXES];
   logic [OUT_BITS-1:0]       max_ff [NUM_AXES];
   logic [AXIS_BITS-1:0]      axis_ff;
   logic                      sdown_ff;
   logic                      last_ff;

   logic                      out_free, emit, last;
   logic [AXIS_BITS-1:0]      sel;
   logic [NUM_AXES-1:0]       sel_hot, rem;

   // pick the lowest pending axis
   always_comb begin
      priority if (mask_ff[0]) begin
         sel = AXIS_X;
      end else if (mask_ff[1]) begin
         sel = AXIS_Y;
      end else begin
         sel = AXIS_Z;
      end
      sel_hot  = NUM_AXES'(1) << sel;
      rem      = mask_ff & ~sel_hot;
      last     = (rem == '0);
      out_free = !rsp_valid_ff || rsp.ready;
      emit     = pend_valid_ff && out_free;
      can_take = !pend_valid_ff || (emit && last);
   end

   // advance the pending set
   always_comb begin
      pend_valid_in = pend_valid_ff;
      mask_in       = mask_ff;
      if (emit) begin
         pend_valid_in = !last;
         mask_in       = rem;
      end
      if (load) begin
         pend_valid_in = 1'b1;
         for (int k = 0; k < NUM_AXES; k++) begin
            mask_in[k] = lane_res[k].near;
         end
      end
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold the old box and the new edges of the request
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            down_ff[k] <= lane_res[k].down;
            low_ff[k]  <= lane_res[k].old_low;
            high_ff[k] <= lane_res[k].old_high;
            edge_ff[k] <= lane_res[k].edge_val;
         end
      end
   end

   // build one slab into the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            min_ff[k] <= (sel_hot[k] && down_ff[sel])  ? edge_ff[sel] : low_ff[k];
            max_ff[k] <= (sel_hot[k] && !down_ff[sel]) ? edge_ff[sel] : high_ff[k];
         end
         axis_ff  <= sel;
         sdown_ff <= down_ff[sel];
         last_ff  <= last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.drop_min_x = min_ff[0];
   assign rsp.drop_min_y = min_ff[1];
   assign rsp.drop_min_z = min_ff[2];
   assign rsp.drop_max_x = max_ff[0];
   assign rsp.drop_max_y = max_ff[1];
   assign rsp.drop_max_z = max_ff[2];
   assign rsp.shift_axis = axis_ff;
   assign rsp.shift_down = sdown_ff;
   assign rsp.last_slab  = last_ff;

endmodule

// ===== sv/sliding_local_map_box_core.sv =====
// Sliding local map box. Each request carries one sensor position; the first
// one after reset places a cube of side cube_side centred on it and returns
// nothing. Later positions are tested on all three axes at once, one lane per
// axis, against the threshold T = move_factor*detect_range/256; every axis
// near an edge shifts the box by the move distance and returns one slab
// response in x, y, z order, the final one marked by last_slab. A moving request
// is held in the merge stage's pending registers; its slabs then enter the output
// register one per cycle while the response port is not stalled, and a new
// position is taken in the same cycle as the last slab of the one before; the
// slab merge stage is what sets this rate. The threshold and move distance come
// from a four stage pipeline fed by the registers, so after reset and after
// every register write the request side stays closed until it has settled.
module sliding_local_map_box_core #(
   parameter int COORD_BITS = slmb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   slmb_req_if.sink                           req_bus,
   slmb_rsp_if.source                         rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [slmb_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [slmb_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import slmb_pkg::*;

   derive_type           drv;
   logic                 busy;
   logic                 can_take;
   logic                 accept, place, apply, load;
   logic                 box_valid_ff, box_valid_in;
   logic [NUM_AXES-1:0]  near_vec;
   lane_res_type         lane_res [NUM_AXES];
   logic signed [OUT_BITS-1:0] pos_arr [NUM_AXES];

   slmb_derive u_derive (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .drv       (drv),
      .busy      (busy)
   );

   // request handshake
   assign req_bus.ready = !busy && can_take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign place         = accept && !box_valid_ff;
   assign apply         = accept && box_valid_ff;
   assign box_valid_in  = box_valid_ff || accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
      end else begin
         box_valid_ff <= box_valid_in;
      end
   end

   assign pos_arr[0] = req_bus.pos_x;
   assign pos_arr[1] = req_bus.pos_y;
   assign pos_arr[2] = req_bus.pos_z;

   // one lane per axis
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      slmb_lane #(.COORD_BITS(COORD_BITS)) u_lane (
         .clock  (clock),
         .pos_in (pos_arr[g]),
         .place  (place),
         .apply  (apply),
         .drv    (drv),
         .res    (lane_res[g])
      );
      assign near_vec[g] = lane_res[g].near;
   end

   // hand the request to the merge stage only when some axis moved
   assign load = apply && (near_vec != '0);

   slmb_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .lane_res (lane_res),
      .can_take (can_take),
      .rsp      (rsp_bus)
   );

endmodule

// ===== sv/slmb_checker.sv =====
module slmb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [slmb_pkg::AXIS_BITS-1:0]   shift_axis,
   input logic                             shift_down,
   input logic                             last_slab,
   input logic [slmb_pkg::OUT_BITS-1:0]    drop_min_x,
   input logic [slmb_pkg::OUT_BITS-1:0]    drop_max_x,
   input logic                             csr_wr_en
);
   import slmb_pkg::*;

   // reset closes both sides
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or request open right after reset");

   // a register write closes the request side while values settle
   a_cfg_closes: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_ready)
      else $error("request taken while derived values settle");

   // z is the last axis, so a z slab always ends the position
   a_z_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !last_slab) |-> (shift_axis != AXIS_Z))
      else $error("z slab not marked last");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(shift_axis)
         && $stable(shift_down) && $stable(last_slab)
         && $stable(drop_min_x) && $stable(drop_max_x))
      else $error("stalled response changed");

endmodule

bind sliding_local_map_box_core slmb_checker u_slmb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .shift_axis (rsp_bus.shift_axis),
   .shift_down (rsp_bus.shift_down),
   .last_slab  (rsp_bus.last_slab),
   .drop_min_x (rsp_bus.drop_min_x),
   .drop_max_x (rsp_bus.drop_max_x),
   .csr_wr_en  (csr_wr_en)
);
